FILE: hdl/butterworth_bin_response_defines.svh
// Assertion helpers, clocked on clk_i, off while rst_ni is low.
`ifndef BUTTERWORTH_BIN_RESPONSE_DEFINES_SVH
`define BUTTERWORTH_BIN_RESPONSE_DEFINES_SVH

// Consequent checked in the same cycle.
`define BBR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the following cycle.
`define BBR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/bbr_pkg.sv
package bbr_pkg;

  typedef enum logic [1:0] {
    FT_BRICK    = 2'd0,
    FT_LOWPASS  = 2'd1,
    FT_HIGHPASS = 2'd2,
    FT_BANDPASS = 2'd3
  } filter_type_e;

  localparam logic [1:0] REG_FILTER_TYPE = 2'd0;
  localparam logic [1:0] REG_LOW_CUTOFF  = 2'd1;
  localparam logic [1:0] REG_HIGH_CUTOFF = 2'd2;
  localparam logic [1:0] REG_ORDER       = 2'd3;

  localparam logic [15:0] UNITY       = 16'd32768;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [15:0] ROUND_HALF  = 16'd16384;

  localparam int DIV1_STEPS = 31;
  localparam int DIV2_STEPS = 33;
  localparam int SQRT_STEPS = 17;
  // lane latency without the power chain
  localparam int LANE_FIXED_LAT = 1 + DIV1_STEPS + 1 + 1 + DIV2_STEPS + SQRT_STEPS + 1;

endpackage

FILE: hdl/bbr_lane.sv
module bbr_lane #(
  parameter int MAX_ORDER = 8,
  parameter bit IS_HIGH   = 1'b0
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [11:0]                        bin_i,
  input  logic [19:0]                        cutoff_i,
  input  logic [$clog2(MAX_ORDER+1)-1:0]     order_i,
  output logic [15:0]                        gain_o
);

  localparam int D1 = bbr_pkg::DIV1_STEPS;
  localparam int D2 = bbr_pkg::DIV2_STEPS;
  localparam int SQ = bbr_pkg::SQRT_STEPS;

  // ratio setup
  logic [19:0] b_ext, c_ext;
  logic        flat_d;
  logic [19:0] a_lo_q, a_hi_q;
  logic        a_flat_q;

  assign b_ext  = {bin_i, 8'd0};
  assign c_ext  = (cutoff_i == 20'd0) ? 20'd1 : cutoff_i;
  assign flat_d = IS_HIGH ? (b_ext >= c_ext) : (b_ext <= c_ext);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_lo_q   <= (b_ext < c_ext) ? b_ext : c_ext;
      a_hi_q   <= (b_ext < c_ext) ? c_ext : b_ext;
      a_flat_q <= flat_d;
    end
  end

  // r = lo * 2^30 / hi, one quotient bit per stage
  logic [19:0] d1_rem_q  [D1];
  logic [30:0] d1_quo_q  [D1];
  logic [19:0] d1_hi_q   [D1];
  logic        d1_flat_q [D1];

  for (genvar k = 0; k < D1; k++) begin : g_div1
    logic [20:0] rem2;
    logic [30:0] quo_in;
    logic [19:0] hi_in;
    logic        flat_in;
    logic        ge;
    if (k == 0) begin : g_first
      assign rem2    = {1'b0, a_lo_q};
      assign quo_in  = '0;
      assign hi_in   = a_hi_q;
      assign flat_in = a_flat_q;
    end else begin : g_next
      assign rem2    = {d1_rem_q[k-1], 1'b0};
      assign quo_in  = d1_quo_q[k-1];
      assign hi_in   = d1_hi_q[k-1];
      assign flat_in = d1_flat_q[k-1];
    end
    assign ge = rem2 >= {1'b0, hi_in};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d1_rem_q[k]  <= ge ? 20'(rem2 - {1'b0, hi_in}) : rem2[19:0];
        d1_quo_q[k]  <= {quo_in[29:0], ge};
        d1_hi_q[k]   <= hi_in;
        d1_flat_q[k] <= flat_in;
      end
    end
  end

  // p = r^n, one multiply per stage
  logic [30:0] pw_p_q    [MAX_ORDER];
  logic [30:0] pw_r_q    [MAX_ORDER];
  logic        pw_flat_q [MAX_ORDER];

  for (genvar k = 0; k < MAX_ORDER; k++) begin : g_pow
    logic [30:0] p_in, r_in;
    logic        flat_in;
    logic [61:0] prod;
    if (k == 0) begin : g_first
      assign p_in    = bbr_pkg::ONE_Q30;
      assign r_in    = d1_quo_q[D1-1];
      assign flat_in = d1_flat_q[D1-1];
    end else begin : g_next
      assign p_in    = pw_p_q[k-1];
      assign r_in    = pw_r_q[k-1];
      assign flat_in = pw_flat_q[k-1];
    end
    assign prod = p_in * r_in;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pw_p_q[k]    <= (32'(order_i) > k) ? prod[60:30] : p_in;
        pw_r_q[k]    <= r_in;
        pw_flat_q[k] <= flat_in;
      end
    end
  end

  // D = 1 + p^2, numerator N
  logic [61:0] sq_prod;
  logic [31:0] sq_d_q;
  logic [30:0] sq_n_q;

  assign sq_prod = pw_p_q[MAX_ORDER-1] * pw_p_q[MAX_ORDER-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_d_q <= {1'b0, bbr_pkg::ONE_Q30} + {1'b0, sq_prod[60:30]};
      sq_n_q <= pw_flat_q[MAX_ORDER-1] ? bbr_pkg::ONE_Q30 : pw_p_q[MAX_ORDER-1];
    end
  end

  logic [61:0] nn_q;
  logic [31:0] nn_d_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nn_q   <= sq_n_q * sq_n_q;
      nn_d_q <= sq_d_q;
    end
  end

  // Q = 4 N^2 / D
  logic [31:0] d2_rem_q [D2];
  logic [31:0] d2_low_q [D2];
  logic [32:0] d2_quo_q [D2];
  logic [31:0] d2_d_q   [D2];

  for (genvar k = 0; k < D2; k++) begin : g_div2
    logic [32:0] rem2;
    logic [31:0] low_in;
    logic [32:0] quo_in;
    logic [31:0] d_in;
    logic        ge;
    if (k == 0) begin : g_first
      assign rem2   = {2'b00, nn_q[60:30]};
      assign low_in = {nn_q[29:0], 2'b00};
      assign quo_in = '0;
      assign d_in   = nn_d_q;
    end else begin : g_next
      assign rem2   = {d2_rem_q[k-1], d2_low_q[k-1][31]};
      assign low_in = {d2_low_q[k-1][30:0], 1'b0};
      assign quo_in = d2_quo_q[k-1];
      assign d_in   = d2_d_q[k-1];
    end
    assign ge = rem2 >= {1'b0, d_in};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d2_rem_q[k] <= ge ? 32'(rem2 - {1'b0, d_in}) : rem2[31:0];
        d2_low_q[k] <= low_in;
        d2_quo_q[k] <= {quo_in[31:0], ge};
        d2_d_q[k]   <= d_in;
      end
    end
  end

  // isqrt(Q), one result bit per stage
  logic [16:0] sr_res_q [SQ];
  logic [32:0] sr_x_q   [SQ];

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    logic [16:0] res_in, cand;
    logic [32:0] x_in;
    logic [33:0] cand_sq;
    if (k == 0) begin : g_first
      assign res_in = '0;
      assign x_in   = d2_quo_q[D2-1];
    end else begin : g_next
      assign res_in = sr_res_q[k-1];
      assign x_in   = sr_x_q[k-1];
    end
    assign cand    = res_in | (17'd1 << (SQ - 1 - k));
    assign cand_sq = cand * cand;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sr_res_q[k] <= (cand_sq <= {1'b0, x_in}) ? cand : res_in;
        sr_x_q[k]   <= x_in;
      end
    end
  end

  // largest odd t below the root gives g = (t + 1) / 2
  logic [17:0] rnd;
  logic [15:0] gain_q;

  assign rnd = {1'b0, sr_res_q[SQ-1]} + 18'd1;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gain_q <= rnd[16:1];
    end
  end

  assign gain_o = gain_q;

endmodule

FILE: hdl/butterworth_bin_response.sv
// Butterworth bin response: one frequency bin in, its real filter gain out
// in unsigned Q1.15 (32768 = 1.0), for brick-wall, lowpass, highpass or
// bandpass as set by filter_type. Cutoffs are Q12.8 bins. One bin is taken
// every clock while the output is not stalled; each result passes through the
// two pipelined restoring dividers, the power chain of MAX_ORDER multipliers
// and the square-root stages of each gain lane. A stall on the output side
// holds the whole pipeline. The user must write configuration only while the
// block is idle; the block itself does not enforce it.
`include "butterworth_bin_response_defines.svh"

module butterworth_bin_response #(
  parameter int MAX_ORDER = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [11:0] bin_index, [15:12] zero
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // [11:0] bin_out, [27:12] gain, [31:28] zero
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i
);

  localparam int OW  = $clog2(MAX_ORDER + 1);
  localparam int LAT = bbr_pkg::LANE_FIXED_LAT + MAX_ORDER;

  bbr_pkg::filter_type_e ftype_q;
  logic [19:0] low_cut_q, high_cut_q;
  logic [3:0]  order_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ftype_q    <= bbr_pkg::FT_LOWPASS;
      low_cut_q  <= 20'd256;
      high_cut_q <= 20'd25600;
      order_q    <= 4'd4;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bbr_pkg::REG_FILTER_TYPE: ftype_q    <= bbr_pkg::filter_type_e'(cfg_data_i[1:0]);
        bbr_pkg::REG_LOW_CUTOFF:  low_cut_q  <= cfg_data_i;
        bbr_pkg::REG_HIGH_CUTOFF: high_cut_q <= cfg_data_i;
        bbr_pkg::REG_ORDER:       order_q    <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // order clamped to 1..MAX_ORDER
  logic [OW-1:0] order_eff;
  always_comb begin
    if (order_q == 4'd0) begin
      order_eff = OW'(1);
    end else if (32'(order_q) > MAX_ORDER) begin
      order_eff = OW'(MAX_ORDER);
    end else begin
      order_eff = OW'(order_q);
    end
  end

  logic en;
  logic m_vld_q;
  assign en              = !m_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  logic [15:0] lp_gain, hp_gain;

  bbr_lane #(.MAX_ORDER(MAX_ORDER), .IS_HIGH(1'b0)) u_lp (
    .clk_i   (clk_i),
    .en_i    (en),
    .bin_i   (s_axis_tdata_i[11:0]),
    .cutoff_i(high_cut_q),
    .order_i (order_eff),
    .gain_o  (lp_gain)
  );

  bbr_lane #(.MAX_ORDER(MAX_ORDER), .IS_HIGH(1'b1)) u_hp (
    .clk_i   (clk_i),
    .en_i    (en),
    .bin_i   (s_axis_tdata_i[11:0]),
    .cutoff_i(low_cut_q),
    .order_i (order_eff),
    .gain_o  (hp_gain)
  );

  // sideband alongside the lanes
  logic        sb_vld_q  [LAT];
  logic [11:0] sb_bin_q  [LAT];
  logic        sb_last_q [LAT];

  for (genvar k = 0; k < LAT; k++) begin : g_sb
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sb_vld_q[k] <= 1'b0;
      end else if (en) begin
        sb_vld_q[k] <= (k == 0) ? (s_axis_tvalid_i) : sb_vld_q[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sb_bin_q[k]  <= (k == 0) ? s_axis_tdata_i[11:0] : sb_bin_q[(k == 0) ? 0 : k-1];
        sb_last_q[k] <= (k == 0) ? s_axis_tlast_i : sb_last_q[(k == 0) ? 0 : k-1];
      end
    end
  end

  // gain select
  logic [19:0] f_q8;
  logic [31:0] bp_prod;
  logic [30:0] bp_sum;
  logic [15:0] gain_d;

  assign f_q8    = {sb_bin_q[LAT-1], 8'd0};
  assign bp_prod = hp_gain * lp_gain;
  assign bp_sum  = bp_prod[30:0] + {15'd0, bbr_pkg::ROUND_HALF};

  always_comb begin
    case (ftype_q)
      bbr_pkg::FT_BRICK:
        gain_d = (f_q8 >= low_cut_q && f_q8 <= high_cut_q) ? bbr_pkg::UNITY : 16'd0;
      bbr_pkg::FT_LOWPASS:  gain_d = lp_gain;
      bbr_pkg::FT_HIGHPASS: gain_d = hp_gain;
      bbr_pkg::FT_BANDPASS: gain_d = bp_sum[30:15];
      default:              gain_d = 16'd0;
    endcase
  end

  logic [11:0] m_bin_q;
  logic [15:0] m_gain_q;
  logic        m_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en) begin
      m_vld_q <= sb_vld_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_bin_q  <= sb_bin_q[LAT-1];
      m_gain_q <= gain_d;
      m_last_q <= sb_last_q[LAT-1];
    end
  end

  assign m_axis_tvalid_o = m_vld_q;
  assign m_axis_tdata_o  = {4'd0, m_gain_q, m_bin_q};
  assign m_axis_tlast_o  = m_last_q;

  `BBR_ASSERT_NOW(a_gain_range, m_vld_q, m_gain_q <= bbr_pkg::UNITY, "gain above unity")
  `BBR_ASSERT_NOW(a_brick_levels, m_vld_q && ftype_q == bbr_pkg::FT_BRICK,
    m_gain_q == 16'd0 || m_gain_q == bbr_pkg::UNITY, "brick-wall gain not 0 or 1")
  `BBR_ASSERT_NOW(a_lp_dc, m_vld_q && ftype_q == bbr_pkg::FT_LOWPASS && m_bin_q == 12'd0,
    m_gain_q == bbr_pkg::UNITY, "lowpass DC gain not unity")
  `BBR_ASSERT_NEXT(a_req_enters, s_axis_tvalid_i && s_axis_tready_o, sb_vld_q[0],
    "accepted request not in pipeline")

endmodule

FILE: sim/tb_butterworth_bin_response.sv
`timescale 1ns / 1ps

module tb_butterworth_bin_response;

  localparam int LATENCY = 86 + 8;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic [11:0] bin;
    logic [15:0] gain;
    logic        last;
  } gain_result_t;

  class gain_scoreboard;
    gain_result_t pending_q[$];
    int errors;
    logic [1:0]  ftype;
    logic [19:0] low_cut;
    logic [19:0] high_cut;
    logic [3:0]  order;

    function void reset_regs();
      ftype = bbr_pkg::FT_LOWPASS;
      low_cut = 20'd256;
      high_cut = 20'd25600;
      order = 4'd4;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [19:0] val);
      case (idx)
        bbr_pkg::REG_FILTER_TYPE: ftype = val[1:0];
        bbr_pkg::REG_LOW_CUTOFF:  low_cut = val;
        bbr_pkg::REG_HIGH_CUTOFF: high_cut = val;
        bbr_pkg::REG_ORDER:       order = val[3:0];
        default: ;
      endcase
    endfunction

    function logic [15:0] nearest_gain(logic [63:0] num, logic [63:0] den);
      logic [127:0] lim;
      logic [127:0] t;
      logic [16:0] g;
      logic [16:0] cand;
      lim = 128'd4 * num * num;
      g = 0;
      for (int b = 15; b >= 0; b--) begin
        cand = g | (17'd1 << b);
        t = 2 * cand - 1;
        if (cand <= 17'd32768 && t * t * den <= lim) g = cand;
      end
      return g[15:0];
    endfunction

    function logic [15:0] butter(logic [11:0] bin, logic [19:0] cut, int n, bit high);
      logic [63:0] b, c, lo, hi, r, p, s, d;
      bit flat;
      b = 64'(bin) << 8;
      c = (cut == 0) ? 64'd1 : 64'(cut);
      lo = (b < c) ? b : c;
      hi = (b < c) ? c : b;
      r = (lo << 30) / hi;
      p = 64'd1 << 30;
      for (int k = 0; k < n; k++) p = (p * r) >> 30;
      s = (p * p) >> 30;
      d = (64'd1 << 30) + s;
      flat = high ? (b >= c) : (b <= c);
      return nearest_gain(flat ? (64'd1 << 30) : p, d);
    endfunction

    function void note_request(logic [11:0] bin, logic last);
      gain_result_t e;
      int n;
      logic [31:0] hp, lp;
      logic [19:0] f;
      n = (order == 0) ? 1 : (order > 8 ? 8 : int'(order));
      e.bin = bin;
      e.last = last;
      f = 20'(bin) << 8;
      case (ftype)
        bbr_pkg::FT_BRICK:
          e.gain = (f >= low_cut && f <= high_cut) ? bbr_pkg::UNITY : 16'd0;
        bbr_pkg::FT_LOWPASS: e.gain = butter(bin, high_cut, n, 1'b0);
        bbr_pkg::FT_HIGHPASS: e.gain = butter(bin, low_cut, n, 1'b1);
        default: begin
          hp = 32'(butter(bin, low_cut, n, 1'b1));
          lp = 32'(butter(bin, high_cut, n, 1'b0));
          e.gain = 16'((hp * lp + 32'd16384) >> 15);
        end
      endcase
      pending_q = {pending_q, e};
    endfunction

    function void check_result(gain_result_t got);
      gain_result_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result bin=%0d gain=%0d last=%0b",
                 $time, got.bin, got.gain, got.last);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (e !== got) begin
        $display("%0t: mismatch expected bin=%0d gain=%0d last=%0b",
                 $time, e.bin, e.gain, e.last,
                 " actual bin=%0d gain=%0d last=%0b", got.bin, got.gain, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid_i = 0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = 0;
  logic        s_axis_tlast_i = 0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 0;
  logic [31:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = 0;
  logic [19:0] cfg_data_i = 0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  longint cycles = 0;
  gain_scoreboard sb;

  always #5 clk_i = ~clk_i;

  butterworth_bin_response dut (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result({m_axis_tdata_o[11:0], m_axis_tdata_o[27:12], m_axis_tlast_o});
    m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_cfg(logic [1:0] idx, logic [19:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
  endtask

  task automatic send_bin(logic [11:0] bin, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {4'd0, bin};
    s_axis_tlast_i <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(bin, last);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic set_all(logic [1:0] t, logic [19:0] lo, logic [19:0] hi, logic [3:0] n);
    drain();
    write_cfg(bbr_pkg::REG_FILTER_TYPE, 20'(t));
    write_cfg(bbr_pkg::REG_LOW_CUTOFF, lo);
    write_cfg(bbr_pkg::REG_HIGH_CUTOFF, hi);
    write_cfg(bbr_pkg::REG_ORDER, 20'(n));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) send_bin(12'($urandom), 1'($urandom_range(1)));
      else send_bin(12'($urandom_range(2048)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    logic [19:0] lo, hi;
    sb = new();
    sb.reset_regs();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: reset config, field extremes
    send_idle_pct = 27; recv_idle_pct = 45;
    send_bin(12'd0, 1'b0); send_bin(12'd1, 1'b0); send_bin(12'd100, 1'b0);
    send_bin(12'd2048, 1'b0); send_bin(12'hFFF, 1'b1);
    set_all(bbr_pkg::FT_HIGHPASS, 20'd0, 20'd0, 4'd0);
    send_bin(12'd0, 1'b0); send_bin(12'd1, 1'b0); send_bin(12'hFFF, 1'b1);
    set_all(bbr_pkg::FT_BANDPASS, 20'd2560, 20'd51200, 4'd15);
    send_bin(12'd0, 1'b0); send_bin(12'd10, 1'b0); send_bin(12'd200, 1'b0);
    send_bin(12'd1000, 1'b1);
    set_all(bbr_pkg::FT_BRICK, 20'd0, 20'hFFFFF, 4'd8);
    send_bin(12'd0, 1'b0); send_bin(12'hFFF, 1'b1);
    set_all(bbr_pkg::FT_BRICK, 20'd51200, 20'd2560, 4'd1);
    send_bin(12'd10, 1'b0); send_bin(12'd100, 1'b1);
    set_all(bbr_pkg::FT_BRICK, 20'd2560, 20'd51200, 4'd1);
    send_bin(12'd9, 1'b0); send_bin(12'd10, 1'b0); send_bin(12'd200, 1'b0);
    send_bin(12'd201, 1'b1);

    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin send_idle_pct = 45; recv_idle_pct = 27; end
      if (ph == 8) begin send_idle_pct = 0; recv_idle_pct = 0; end
      lo = 20'($urandom_range(1, 524288));
      hi = 20'($urandom_range(1, 524288));
      if (ph == 11) begin lo = 20'd1; hi = 20'd524288; end
      if (ph == 10) begin lo = 20'hFFFFF; hi = 20'hFFFFF; end
      set_all(2'(ph), lo, hi, 4'($urandom));
      random_phase(44);
    end

    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
